// ===== rtl/chs_pkg.sv =====
// Shared types and constants of the chained hash set.
package chs_pkg;

  localparam int OPCODE_W  = 2;
  localparam int IN_KEY_W  = 32;
  localparam int STATUS_W  = 3;
  localparam int BKT_IDX_W = 6;

  localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STS_INSERTED  = 3'd0,
    STS_PRESENT   = 3'd1,
    STS_DELETED   = 3'd2,
    STS_DEL_MISS  = 3'd3,
    STS_FOUND     = 3'd4,
    STS_NOT_FOUND = 3'd5,
    STS_FULL      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_READ,
    ST_UPDATE
  } state_t;

endpackage

// ===== rtl/chs_if.sv =====
// Request and response channel interfaces of the chained hash set.
interface chs_req_if import chs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [IN_KEY_W-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink (input valid, input opcode, input key, output ready);
endinterface

interface chs_rsp_if import chs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 found;
  logic [BKT_IDX_W-1:0] bucket_index;

  modport source (output valid, output status, output found, output bucket_index, input ready);
  modport sink (input valid, input status, input found, input bucket_index, output ready);
endinterface

// ===== rtl/chained_hash_set.sv =====
// Chained hash set: top level with bucket reduction, bucket memories and sequencer.
//
// Usage:
//   in_req  (sink)   : opcode (add, delete, find) and a 32-bit key; one transfer per request.
//   out_rsp (source) : status, found flag and bucket index; exactly one transfer per request,
//                      in request order.
//   The bucket is the key (low KEY_BITS bits) modulo NUM_BUCKETS: the DIV step multiplies the
//   key by a fixed reciprocal, the REM step subtracts quotient times NUM_BUCKETS from the key.
//   The bucket row (keys and valid bits) is then read from two memories, all slots are
//   compared at once and the row is written back on an insert or a delete.
//   After the request transfer the sequencer steps through the multiply, remainder, read and
//   update steps and registers the result in the output register; it takes the next request
//   only once it has returned to the idle step.
//   in_req.ready is high only while the sequencer is idle. A result waits in the output
//   register; the next request may be taken meanwhile, and if the receiver still stalls when
//   that request is ready to write back, the sequencer holds in the update step.
//   Reset: after rst_n is released a clearing pass empties the valid memory, one bucket row a
//   cycle, for NUM_BUCKETS cycles; in_req.ready stays low during it.
module chained_hash_set import chs_pkg::*; #(
  parameter int NUM_BUCKETS      = 40,
  parameter int SLOTS_PER_BUCKET = 8,
  parameter int KEY_BITS         = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  chs_req_if.sink   in_req,
  chs_rsp_if.source out_rsp
);

  // Effective key width, bucket number width and reciprocal shift.
  localparam int KW = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int NS = SLOTS_PER_BUCKET;
  localparam int SH = KW + BW;

  // ceil(2^SH / NUM_BUCKETS): the quotient (key * RECIP) >> SH is exact for every KW-bit key.
  localparam logic [KW:0]   RECIP    = (KW + 1)'(((64'd1 << SH) + 64'(NUM_BUCKETS) - 64'd1)
                                                 / 64'(NUM_BUCKETS));
  localparam logic [KW-1:0] NB_K     = KW'(NUM_BUCKETS);
  localparam logic [BW-1:0] LAST_ROW = BW'(NUM_BUCKETS - 1);

  state_t                state_r, state_nxt;
  logic [OPCODE_W-1:0]   op_r, op_nxt;
  logic [KW-1:0]         key_r, key_nxt;
  logic [2*KW:0]         prod_r, prod_nxt;
  logic [BW-1:0]         rem_r, rem_nxt;
  logic [BW-1:0]         clr_r, clr_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [BKT_IDX_W-1:0]  out_bkt_r, out_bkt_nxt;

  // Bucket memories: one row per bucket.
  logic [NS*KW-1:0]      key_mem [NUM_BUCKETS];
  logic [NS-1:0]         vld_mem [NUM_BUCKETS];
  logic [NS*KW-1:0]      rd_key_r;
  logic [NS-1:0]         rd_vld_r;

  logic                  key_we;
  logic [NS*KW-1:0]      key_wdata;
  logic                  vld_we;
  logic [BW-1:0]         vld_waddr;
  logic [NS-1:0]         vld_wdata;

  logic [KW-1:0]         quo;
  logic [KW-1:0]         quo_nb;
  logic [NS-1:0]         hit_vec;
  logic [NS-1:0]         hit_oh;
  logic [NS-1:0]         free_oh;
  logic                  hit;
  logic                  full;
  logic                  out_free;
  logic [BW+BKT_IDX_W-1:0] bkt_ext;

  assign in_req.ready         = (state_r == ST_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.found        = out_found_r;
  assign out_rsp.bucket_index = out_bkt_r;

  // The output register can take a new result when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_rsp.ready;

  // Quotient from the registered reciprocal product, and quotient times the bucket count.
  assign quo    = KW'(prod_r >> SH);
  assign quo_nb = quo * NB_K;

  // Slot match and slot allocation over the row just read.
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      hit_vec[s] = rd_vld_r[s] && (rd_key_r[s*KW +: KW] == key_r);
    end
    hit_oh  = hit_vec & (~hit_vec + NS'(1));
    free_oh = ~rd_vld_r & (rd_vld_r + NS'(1));
    hit     = |hit_vec;
    full    = &rd_vld_r;
    for (int s = 0; s < NS; s++) begin
      key_wdata[s*KW +: KW] = free_oh[s] ? key_r : rd_key_r[s*KW +: KW];
    end
  end

  assign bkt_ext = {{BKT_IDX_W{1'b0}}, rem_r};

  // Sequencer: next state, datapath control and the result.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    prod_nxt       = prod_r;
    rem_nxt        = rem_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_bkt_nxt    = out_bkt_r;
    key_we         = 1'b0;
    vld_we         = 1'b0;
    vld_waddr      = rem_r;
    vld_wdata      = rd_vld_r;

    // Drop the result once its transfer completes.
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        // Empty one bucket row a cycle.
        vld_we    = 1'b1;
        vld_waddr = clr_r;
        vld_wdata = '0;
        clr_nxt   = clr_r + BW'(1);
        if (clr_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_req.valid) begin
          op_nxt    = in_req.opcode;
          key_nxt   = in_req.key[KW-1:0];
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // Multiply the key by the reciprocal of the bucket count.
        prod_nxt  = (2*KW+1)'(key_r) * (2*KW+1)'(RECIP);
        state_nxt = ST_REM;
      end
      ST_REM: begin
        // Remainder is below the bucket count; keep its BW bits.
        rem_nxt   = BW'(key_r - quo_nb);
        state_nxt = ST_READ;
      end
      ST_READ: begin
        // Row read issued at rem_r; data arrives next cycle.
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hit;
          out_bkt_nxt   = bkt_ext[BKT_IDX_W-1:0];
          state_nxt     = ST_IDLE;
          case (op_r)
            OP_ADD: begin
              if (hit) begin
                out_status_nxt = STS_PRESENT;
              end else if (full) begin
                out_status_nxt = STS_FULL;
              end else begin
                key_we         = 1'b1;
                vld_we         = 1'b1;
                vld_wdata      = rd_vld_r | free_oh;
                out_status_nxt = STS_INSERTED;
              end
            end
            OP_DELETE: begin
              if (hit) begin
                vld_we         = 1'b1;
                vld_wdata      = rd_vld_r & ~hit_oh;
                out_status_nxt = STS_DELETED;
              end else begin
                out_status_nxt = STS_DEL_MISS;
              end
            end
            default: begin
              // Find, and the unused opcode, only report.
              out_status_nxt = hit ? STS_FOUND : STS_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    prod_r       <= prod_nxt;
    rem_r        <= rem_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_bkt_r    <= out_bkt_nxt;
  end

  // Key memory: read the bucket row, write it back with the new key placed.
  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      rd_key_r <= key_mem[rem_r];
    end
    if (key_we) begin
      key_mem[rem_r] <= key_wdata;
    end
  end

  // Valid memory: cleared after reset, updated on insert and delete.
  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      rd_vld_r <= vld_mem[rem_r];
    end
    if (vld_we) begin
      vld_mem[vld_waddr] <= vld_wdata;
    end
  end

endmodule

// ===== rtl/chs_checker.sv =====
// Port-level assertions of the chained hash set and their bind to the top level.
module chs_checker import chs_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [STATUS_W-1:0]  out_status,
  input logic                 out_found,
  input logic [BKT_IDX_W-1:0] out_bucket_index
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_r, pend_nxt;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Requests accepted whose results are not yet delivered.
  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_found)
                                && $stable(out_bucket_index))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready ##1 !in_ready)
    else $error("request taken while the previous one is still in work");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result offered with no request outstanding");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two requests outstanding");

endmodule

bind chained_hash_set chs_checker u_chs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_status       (out_rsp.status),
  .out_found        (out_rsp.found),
  .out_bucket_index (out_rsp.bucket_index)
);
